### sv/swmo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_pkg
// Shared types and codes for the stack with middle-element commands:
// command and status codes, controller states and the control/flag bundles
// that pass between controller and datapath.
// ----------------------------------------------------------------------------
package swmo_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_READ_MID = 2'd2,
    CMD_DEL_MID  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SHIFT,
    S_RESULT
  } state_t;

  // read address sources
  typedef enum logic [1:0] {
    RD_TOP,
    RD_MID,
    RD_MID_NEXT,
    RD_PTR_NEXT2
  } rd_sel_t;

  // write address/data sources
  typedef enum logic {
    WR_PUSH,
    WR_SHIFT
  } wr_src_t;

  typedef struct packed {
    logic         load;
    logic         rd_en;
    rd_sel_t      rd_sel;
    logic         wr_en;
    wr_src_t      wr_src;
    logic         fill_inc;
    logic         fill_dec;
    logic         ptr_load;
    logic         ptr_inc;
    logic         res_set;
    logic         res_from_mem;
    status_code_t res_status;
  } ctrl_t;

  typedef struct packed {
    command_t cmd;
    logic     full;
    logic     empty;
    logic     above_mid;
    logic     shift_more;
  } flags_t;

endpackage
`default_nettype wire

### sv/stack_with_middle_ops.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_middle_ops
// Bounded stack of 32-bit words with push, pop, read-middle and
// delete-middle commands.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   command and value are sampled there. busy stays high until the result
//   has been shown. The result (data, status, count) is valid for exactly
//   one cycle while done is high; the receiver cannot stall it.
//   The middle entry is the one at position count/2 (rounded down) from the
//   bottom of the stack.
// Steps from accept to done, one transaction at a time:
//   push, or any error case:  decode, then result
//   pop, read middle:         decode, read, then result
//   delete middle:            decode, read, shift per entry above middle, result
//   The next transaction can be taken in the cycle after done.
//   Delete middle moves each entry above the middle down one place per
//   cycle, as the entry memory has a single read and a single write port.
// Reset (rst, synchronous) empties the stack and returns to idle; the entry
// memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module stack_with_middle_ops
  import swmo_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [31:0]      data,
  output logic [1:0]       status,
  output logic [4:0]       count
);

  ctrl_t  ctrl;
  flags_t flags;

  swmo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  swmo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .command (command),
    .value   (value),
    .flags   (flags),
    .data    (data),
    .status  (status),
    .count   (count)
  );

endmodule
`default_nettype wire

### sv/swmo_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_ctrl
// Command sequencer: decodes the latched command, steps the memory reads,
// the delete-middle shift loop and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module swmo_ctrl
  import swmo_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire flags_t flags,
  output logic        busy,
  output logic        done,
  output ctrl_t       ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags.cmd == CMD_PUSH || flags.empty) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (flags.cmd == CMD_DEL_MID && flags.above_mid) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (!flags.shift_more) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      S_DECODE: begin
        if (flags.cmd == CMD_PUSH) begin
          ctrl.res_set = 1'b1;
          if (flags.full) begin
            ctrl.res_status = ST_FULL;
          end else begin
            ctrl.res_status = ST_OK;
            ctrl.wr_en      = 1'b1;
            ctrl.wr_src     = WR_PUSH;
            ctrl.fill_inc   = 1'b1;
          end
        end else if (flags.empty) begin
          ctrl.res_set    = 1'b1;
          ctrl.res_status = ST_EMPTY;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = (flags.cmd == CMD_POP) ? RD_TOP : RD_MID;
        end
      end
      S_READ: begin
        ctrl.res_set      = 1'b1;
        ctrl.res_from_mem = 1'b1;
        ctrl.res_status   = ST_OK;
        case (flags.cmd)
          CMD_POP: begin
            ctrl.fill_dec = 1'b1;
          end
          CMD_DEL_MID: begin
            if (flags.above_mid) begin
              ctrl.ptr_load = 1'b1;
              ctrl.rd_en    = 1'b1;
              ctrl.rd_sel   = RD_MID_NEXT;
            end else begin
              ctrl.fill_dec = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        // move the entry fetched last cycle down one place
        ctrl.wr_en   = 1'b1;
        ctrl.wr_src  = WR_SHIFT;
        ctrl.ptr_inc = 1'b1;
        if (flags.shift_more) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_PTR_NEXT2;
        end else begin
          ctrl.fill_dec = 1'b1;
        end
      end
      S_RESULT: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not occupy the block");

  a_write_not_on_result: assert property (@(posedge clk) disable iff (rst)
    done |-> (!ctrl.wr_en && !ctrl.fill_inc && !ctrl.fill_dec))
    else $error("stack changed while its result was shown");

endmodule
`default_nettype wire

### sv/swmo_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_dp
// Datapath: entry memory (one write, one registered read port), fill
// counter, shift pointer, latched command and result registers.
// ----------------------------------------------------------------------------
module swmo_dp
  import swmo_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_t       ctrl,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] value,
  output flags_t           flags,
  output logic [31:0]      data,
  output logic [1:0]       status,
  output logic [4:0]       count
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic [FW-1:0] fill;
  logic [FW-1:0] ptr;
  logic [FW-1:0] mid;
  command_t      cmd;
  logic [31:0]   val;
  logic [31:0]   res_data;
  status_code_t  res_status;

  assign mid = fill >> 1;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd <= command_t'(command);
      val <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.fill_inc) begin
      fill <= fill + FW'(1);
    end else if (ctrl.fill_dec) begin
      fill <= fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ptr_load) begin
      ptr <= mid;
    end else if (ctrl.ptr_inc) begin
      ptr <= ptr + FW'(1);
    end
  end

  always_comb begin
    case (ctrl.rd_sel)
      RD_TOP:       rd_addr = AW'(fill - FW'(1));
      RD_MID:       rd_addr = AW'(mid);
      RD_MID_NEXT:  rd_addr = AW'(mid + FW'(1));
      RD_PTR_NEXT2: rd_addr = AW'(ptr + FW'(2));
      default:      rd_addr = '0;
    endcase
  end

  assign wr_addr = (ctrl.wr_src == WR_PUSH) ? AW'(fill) : AW'(ptr);
  assign wr_data = (ctrl.wr_src == WR_PUSH) ? val : rd_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_set) begin
      res_status <= ctrl.res_status;
      res_data   <= ctrl.res_from_mem ? rd_q : '0;
    end
  end

  assign flags.cmd        = cmd;
  assign flags.full       = (fill == FW'(DEPTH));
  assign flags.empty      = (fill == '0);
  assign flags.above_mid  = ((mid + FW'(1)) < fill);
  assign flags.shift_more = ((ptr + FW'(2)) < fill);

  assign data   = res_data;
  assign status = res_status;
  assign count  = 5'(fill);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill beyond stack depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.fill_inc |-> !flags.full)
    else $error("push accepted on a full stack");

  a_no_remove_when_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.fill_dec |-> !flags.empty)
    else $error("entry removed from an empty stack");

endmodule
`default_nettype wire
